// File: rtl/scsb_pkg.sv
`default_nettype none

package scsb_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned DEF_SCREEN_WIDTH    = 1024;
    localparam int unsigned DEF_SCREEN_HEIGHT   = 768;
    localparam int unsigned DEF_SPRITE_MAX_SIDE = 64;

    // Field widths
    localparam int unsigned SIDE_W   = 7;   // sprite_width, sprite_height
    localparam int unsigned DIM_W    = 10;  // out_width, out_height, origin_row, col, row
    localparam int unsigned TIDX_W   = 12;  // texel_index
    localparam int unsigned COLOR_W  = 32;
    localparam int unsigned ADDR_W   = 20;  // dest_address
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // The quotient stays below sprite_width, so it fits the sprite side width
    localparam int unsigned QW    = SIDE_W;
    localparam int unsigned NUM_W = DIM_W + SIDE_W;   // col * sprite_width
    // Store index: covers a loaded index, a sampled index and the deepest store
    localparam int unsigned IDX_W = 17;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_LOAD    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_ROW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COLOR     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_ENABLE   = 3'd6;

    // What an item carries alongside the division
    typedef struct packed {
        logic               op;
        logic               ok;
        logic [TIDX_W-1:0]  tex_index;
        logic [COLOR_W-1:0] tex_color;
        logic [ADDR_W-1:0]  dest_addr;
    } t_side;

    // Partial state of the two dividers plus the item
    typedef struct packed {
        logic [NUM_W-1:0] rem_x;
        logic [NUM_W-1:0] rem_y;
        logic [QW-1:0]    q_x;
        logic [QW-1:0]    q_y;
        t_side            side;
    } t_div;

endpackage

`default_nettype wire

// File: rtl/scsb_div_step.sv
`default_nettype none

// One restoring step of both dividers: settle quotient bit BIT.
module scsb_div_step import scsb_pkg::*; #(
    parameter int unsigned BIT = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_valid,
    input  wire t_div             i_data,
    input  wire logic [DIM_W-1:0] i_div_x,
    input  wire logic [DIM_W-1:0] i_div_y,
    output logic                  o_valid,
    output t_div                  o_data
);

    logic [NUM_W-1:0] w_sub_x;
    logic [NUM_W-1:0] w_sub_y;
    t_div             n_data;
    logic             r_valid;
    t_div             r_data;

    assign w_sub_x = NUM_W'(i_div_x) << BIT;
    assign w_sub_y = NUM_W'(i_div_y) << BIT;

    always_comb begin
        n_data = i_data;
        if (i_data.rem_x >= w_sub_x) begin
            n_data.rem_x  = i_data.rem_x - w_sub_x;
            n_data.q_x[BIT] = 1'b1;
        end
        if (i_data.rem_y >= w_sub_y) begin
            n_data.rem_y  = i_data.rem_y - w_sub_y;
            n_data.q_y[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// File: rtl/scsb_tex_mem.sv
`default_nettype none

// Texel store: one port, write or registered read.
module scsb_tex_mem import scsb_pkg::*; #(
    parameter int unsigned DEPTH = DEF_SPRITE_MAX_SIDE * DEF_SPRITE_MAX_SIDE,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_addr,
    input  wire logic [COLOR_W-1:0] i_wdata,
    output logic      [COLOR_W-1:0] o_rdata
);

    logic [COLOR_W-1:0] r_mem [DEPTH];
    logic [COLOR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/scaled_colorkey_sprite_blit_core.sv
// Scaled color-keyed sprite blitter, nearest-neighbor sampling.
//
// Input channel (i_in_valid / o_in_stall) takes one item per unstalled cycle.
// A load item writes texel_color into the texel store at texel_index; a draw
// item names one pixel (out_col, out_row) of the scaled rectangle. Output channel
// (o_out_valid / i_out_stall) returns exactly one result item per input item,
// in order: status 1 for a load, 2 for a refused draw, 0 for a drawn pixel
// with its screen address, sampled color and write enable (low on key color).
// Configuration is a plain write port (i_cfg_we / i_cfg_index / i_cfg_data);
// write it only while no item is in flight.
//
// Throughput: one item per cycle while neither channel stalls. The pipeline
// has eleven register stages: the seven restoring-division stages (one
// quotient bit each) plus entry, index, store read and output.
// Stalls ripple back stage by stage, so empty stages still fill while the
// output holds; input stalls only when every stage holds an item.
// Reset (synchronous, active low) empties the pipeline and restores the
// register defaults; the texel store is not cleared and reads garbage until
// written.

`default_nettype none

module scaled_colorkey_sprite_blit_core import scsb_pkg::*; #(
    parameter int unsigned SCREEN_WIDTH    = DEF_SCREEN_WIDTH,
    parameter int unsigned SCREEN_HEIGHT   = DEF_SCREEN_HEIGHT,
    parameter int unsigned SPRITE_MAX_SIDE = DEF_SPRITE_MAX_SIDE
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_operation,
    input  wire logic [TIDX_W-1:0]     i_texel_index,
    input  wire logic [COLOR_W-1:0]    i_texel_color,
    input  wire logic [DIM_W-1:0]      i_out_col,
    input  wire logic [DIM_W-1:0]      i_out_row,
    // result items
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [ADDR_W-1:0]          o_dest_address,
    output logic [COLOR_W-1:0]         o_pixel_color,
    output logic                       o_write_enable,
    output logic [STATUS_W-1:0]        o_status
);

    // Stage map: 0 entry, 1..QW division, QW+1 index, QW+2 store read, QW+3 output
    localparam int unsigned STAGES = QW + 4;
    localparam int unsigned ST_X   = QW + 1;
    localparam int unsigned ST_M   = QW + 2;
    localparam int unsigned ST_O   = QW + 3;

    localparam int unsigned DEPTH = SPRITE_MAX_SIDE * SPRITE_MAX_SIDE;
    localparam int unsigned AW    = $clog2(DEPTH);

    // Compare width: holds every bound and origin_row + out_height
    localparam int unsigned CW =
        $clog2(SCREEN_WIDTH + SCREEN_HEIGHT + SPRITE_MAX_SIDE + 2048) + 1;
    localparam logic [CW-1:0] SW_C  = CW'(SCREEN_WIDTH);
    localparam logic [CW-1:0] SH_C  = CW'(SCREEN_HEIGHT);
    localparam logic [CW-1:0] SMS_C = CW'(SPRITE_MAX_SIDE);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam int unsigned   PW    = DIM_W + 1 + CW;
    localparam logic [IDX_W-1:0] DEPTH_C = IDX_W'(DEPTH);

    // ---------------- configuration registers ----------------
    logic [SIDE_W-1:0]  r_sprite_width;
    logic [SIDE_W-1:0]  r_sprite_height;
    logic [DIM_W-1:0]   r_out_width;
    logic [DIM_W-1:0]   r_out_height;
    logic [DIM_W-1:0]   r_origin_row;
    logic [COLOR_W-1:0] r_key_color;
    logic               r_draw_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sprite_width  <= SIDE_W'(1);
            r_sprite_height <= SIDE_W'(1);
            r_out_width     <= DIM_W'(1);
            r_out_height    <= DIM_W'(1);
            r_origin_row    <= '0;
            r_key_color     <= 32'h00FF_00FF;
            r_draw_enable   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data[SIDE_W-1:0];
                CFG_SPRITE_HEIGHT: r_sprite_height <= i_cfg_data[SIDE_W-1:0];
                CFG_OUT_WIDTH:     r_out_width     <= i_cfg_data[DIM_W-1:0];
                CFG_OUT_HEIGHT:    r_out_height    <= i_cfg_data[DIM_W-1:0];
                CFG_ORIGIN_ROW:    r_origin_row    <= i_cfg_data[DIM_W-1:0];
                CFG_KEY_COLOR:     r_key_color     <= i_cfg_data[COLOR_W-1:0];
                CFG_DRAW_ENABLE:   r_draw_enable   <= i_cfg_data[0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ---------------- stage handshake ----------------
    // A stage may advance when it is empty or the stage after it advances.
    logic [STAGES-1:0] w_valid;
    logic [STAGES-1:0] w_rdy;

    assign w_rdy[STAGES-1] = !w_valid[STAGES-1] || !i_out_stall;
    for (genvar gk = 0; gk < STAGES - 1; gk++) begin : g_rdy
        assign w_rdy[gk] = !w_valid[gk] || w_rdy[gk+1];
    end

    assign o_in_stall = !w_rdy[0];

    // ---------------- stage 0: checks, products, screen address ----------------
    logic [DIM_W:0]   w_row_sum;
    logic [DIM_W:0]   w_org_end;
    logic [PW-1:0]    w_addr_full;
    logic             w_ok;
    t_div             n_s0;
    t_div             r_s0;
    logic             r_s0_valid;

    assign w_row_sum   = (DIM_W+1)'(r_origin_row) + (DIM_W+1)'(i_out_row);
    assign w_org_end   = (DIM_W+1)'(r_origin_row) + (DIM_W+1)'(r_out_height);
    assign w_addr_full = PW'(w_row_sum) * PW'(SW_C) + PW'(i_out_col);

    // Refuse on disabled drawing, bad sizes, rectangle off the bottom, or a
    // pixel outside the rectangle.
    assign w_ok = r_draw_enable
        && (CW'(r_sprite_width)  >= ONE_C) && (CW'(r_sprite_width)  <= SMS_C)
        && (CW'(r_sprite_height) >= ONE_C) && (CW'(r_sprite_height) <= SMS_C)
        && (CW'(r_out_width)  >= ONE_C) && (CW'(r_out_width)  <  SW_C)
        && (CW'(r_out_height) >= ONE_C) && (CW'(r_out_height) <= SH_C)
        && (CW'(w_org_end) <= SH_C)
        && (i_out_col < r_out_width) && (i_out_row < r_out_height);

    always_comb begin
        n_s0.rem_x          = NUM_W'(i_out_col) * NUM_W'(r_sprite_width);
        n_s0.rem_y          = NUM_W'(i_out_row) * NUM_W'(r_sprite_height);
        n_s0.q_x            = '0;
        n_s0.q_y            = '0;
        n_s0.side.op        = i_operation;
        n_s0.side.ok        = w_ok;
        n_s0.side.tex_index = i_texel_index;
        n_s0.side.tex_color = i_texel_color;
        n_s0.side.dest_addr = w_addr_full[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_rdy[0]) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_s0 <= n_s0;
        end
    end

    assign w_valid[0] = r_s0_valid;

    // ---------------- stages 1..QW: restoring division, MSB first ----------------
    t_div w_div [QW+1];

    assign w_div[0] = r_s0;

    for (genvar gi = 0; gi < QW; gi++) begin : g_div
        scsb_div_step #(
            .BIT (QW - 1 - gi)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_rdy[gi+1]),
            .i_valid (w_valid[gi]),
            .i_data  (w_div[gi]),
            .i_div_x (r_out_width),
            .i_div_y (r_out_height),
            .o_valid (w_valid[gi+1]),
            .o_data  (w_div[gi+1])
        );
    end

    // ---------------- index stage: store address and access kind ----------------
    logic [IDX_W-1:0] w_draw_idx;
    logic [IDX_W-1:0] w_tex_idx;
    t_side            r_x_side;
    logic [AW-1:0]    r_x_addr;
    logic             r_x_wr;
    logic             r_x_rd;
    logic             r_x_valid;

    assign w_draw_idx = IDX_W'(w_div[QW].q_y) * IDX_W'(r_sprite_width)
                      + IDX_W'(w_div[QW].q_x);
    assign w_tex_idx  = (w_div[QW].side.op == OP_LOAD) ? IDX_W'(w_div[QW].side.tex_index)
                                                       : w_draw_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else if (w_rdy[ST_X]) begin
            r_x_valid <= w_valid[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_X]) begin
            r_x_side <= w_div[QW].side;
            r_x_addr <= w_tex_idx[AW-1:0];
            // a load past the store depth is dropped
            r_x_wr   <= (w_div[QW].side.op == OP_LOAD) && (w_tex_idx < DEPTH_C);
            r_x_rd   <= (w_div[QW].side.op == OP_DRAW) && w_div[QW].side.ok;
        end
    end

    assign w_valid[ST_X] = r_x_valid;

    // ---------------- store stage ----------------
    // Loads and draws touch the store at the same stage, so a draw always sees
    // every load accepted before it.
    logic               w_mem_we;
    logic               w_mem_re;
    logic [COLOR_W-1:0] w_rdata;
    t_side              r_m_side;
    logic               r_m_valid;

    assign w_mem_we = w_rdy[ST_M] && r_x_valid && r_x_wr;
    assign w_mem_re = w_rdy[ST_M] && r_x_valid && r_x_rd;

    scsb_tex_mem #(
        .DEPTH (DEPTH)
    ) u_tex_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (r_x_addr),
        .i_wdata (r_x_side.tex_color),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_rdy[ST_M]) begin
            r_m_valid <= r_x_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_M]) begin
            r_m_side <= r_x_side;
        end
    end

    assign w_valid[ST_M] = r_m_valid;

    // ---------------- output stage: key compare and result format ----------------
    logic                r_o_valid;
    logic [ADDR_W-1:0]   r_o_addr;
    logic [COLOR_W-1:0]  r_o_color;
    logic                r_o_we;
    logic [STATUS_W-1:0] r_o_status;
    logic [ADDR_W-1:0]   n_o_addr;
    logic [COLOR_W-1:0]  n_o_color;
    logic                n_o_we;
    logic [STATUS_W-1:0] n_o_status;

    always_comb begin
        n_o_addr   = '0;
        n_o_color  = '0;
        n_o_we     = 1'b0;
        n_o_status = ST_REFUSED;
        if (r_m_side.op == OP_LOAD) begin
            n_o_status = ST_LOAD;
        end else if (r_m_side.ok) begin
            n_o_addr   = r_m_side.dest_addr;
            n_o_color  = w_rdata;
            n_o_we     = (w_rdata != r_key_color);
            n_o_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_rdy[ST_O]) begin
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[ST_O]) begin
            r_o_addr   <= n_o_addr;
            r_o_color  <= n_o_color;
            r_o_we     <= n_o_we;
            r_o_status <= n_o_status;
        end
    end

    assign w_valid[ST_O]  = r_o_valid;
    assign o_out_valid    = r_o_valid;
    assign o_dest_address = r_o_addr;
    assign o_pixel_color  = r_o_color;
    assign o_write_enable = r_o_we;
    assign o_status       = r_o_status;

    // ---------------- assertions ----------------
    // Input holds off only when the whole pipeline is full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&w_valid))
        else $error("input stalled with an empty stage");

    // The single store port never reads and writes at once.
    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("store read and write in one cycle");

    // Loads and refused draws carry no pixel.
    a_blank_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_LOAD || o_status == ST_REFUSED))
        |-> (o_dest_address == '0 && o_pixel_color == '0 && !o_write_enable))
        else $error("non-draw result carries pixel data");

    // A store read is always followed by its pixel result once the stage moves.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_re |=> (r_m_valid && r_m_side.op == OP_DRAW && r_m_side.ok))
        else $error("store read without a matching draw in flight");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
    import scsb_pkg::*;

    // Screen and store geometry, same as the block's defaults
    localparam int unsigned SCR_W    = DEF_SCREEN_WIDTH;
    localparam int unsigned SCR_H    = DEF_SCREEN_HEIGHT;
    localparam int unsigned SIDE_MAX = DEF_SPRITE_MAX_SIDE;
    localparam int unsigned TEXELS   = SIDE_MAX * SIDE_MAX;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned DRAIN_SLACK  = 16;
    localparam int unsigned LONG_HOLD    = 80;      // well past the pipeline depth
    localparam int unsigned CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic               op;
        logic [TIDX_W-1:0]  tidx;
        logic [COLOR_W-1:0] tcolor;
        logic [DIM_W-1:0]   col;
        logic [DIM_W-1:0]   row;
    } t_blit_item;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [COLOR_W-1:0]  color;
        logic                we;
        logic [STATUS_W-1:0] status;
    } t_pixel_result;

    typedef enum int {
        DRAIN_FREE,
        DRAIN_LIGHT,
        DRAIN_HEAVY,
        DRAIN_PERIODIC,
        DRAIN_HOLD
    } t_drain_mode;

    // Mirrors the register file and the texel store; predicts one result per item.
    class pixel_scoreboard;
        logic [COLOR_W-1:0] texels [TEXELS];
        int unsigned        sprite_w, sprite_h, rect_w, rect_h, org_row;
        logic [COLOR_W-1:0] key;
        bit                 enable;
        t_pixel_result      pending_pixels [$];
        int unsigned        mismatches;

        function new();
            sprite_w   = 1;
            sprite_h   = 1;
            rect_w     = 1;
            rect_h     = 1;
            org_row    = 0;
            key        = 32'h00FF_00FF;
            enable     = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_SPRITE_WIDTH:  sprite_w = data[SIDE_W-1:0];
                CFG_SPRITE_HEIGHT: sprite_h = data[SIDE_W-1:0];
                CFG_OUT_WIDTH:     rect_w   = data[DIM_W-1:0];
                CFG_OUT_HEIGHT:    rect_h   = data[DIM_W-1:0];
                CFG_ORIGIN_ROW:    org_row  = data[DIM_W-1:0];
                CFG_KEY_COLOR:     key      = data[COLOR_W-1:0];
                CFG_DRAW_ENABLE:   enable   = data[0];
                default: ;
            endcase
        endfunction

        // Return 1 when a draw at (col, row) is allowed, with the sampled store index.
        function bit sample_index(input logic [DIM_W-1:0] col, input logic [DIM_W-1:0] row,
                                  output int unsigned idx);
            int unsigned sx, sy;
            idx = 0;
            if (!enable) return 1'b0;
            if (sprite_w < 1 || sprite_w > SIDE_MAX) return 1'b0;
            if (sprite_h < 1 || sprite_h > SIDE_MAX) return 1'b0;
            if (rect_w < 1 || rect_w >= SCR_W) return 1'b0;
            if (rect_h < 1 || rect_h > SCR_H) return 1'b0;
            if (org_row + rect_h > SCR_H) return 1'b0;
            if (col >= rect_w || row >= rect_h) return 1'b0;
            sx  = col * sprite_w / rect_w;
            sy  = row * sprite_h / rect_h;
            idx = sy * sprite_w + sx;
            return 1'b1;
        endfunction

        function void take_item(t_blit_item it);
            t_pixel_result r;
            int unsigned   idx, a;
            r = '0;
            if (it.op == OP_LOAD) begin
                if (it.tidx < TEXELS) texels[it.tidx] = it.tcolor;
                r.status = ST_LOAD;
            end else if (!sample_index(it.col, it.row, idx)) begin
                r.status = ST_REFUSED;
            end else begin
                a        = (org_row + it.row) * SCR_W + it.col;
                r.addr   = a[ADDR_W-1:0];
                r.color  = (idx < TEXELS) ? texels[idx] : '0;
                r.we     = (r.color != key);
                r.status = ST_OK;
            end
            pending_pixels.push_back(r);
        endfunction

        function void check_pixel(t_pixel_result got);
            t_pixel_result want;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: addr=%h color=%h we=%b status=%0d",
                             got.addr, got.color, got.we, got.status);
                return;
            end
            want = pending_pixels.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected addr=%h color=%h we=%b status=%0d,",
                              " got addr=%h color=%h we=%b status=%0d"},
                             want.addr, want.color, want.we, want.status,
                             got.addr, got.color, got.we, got.status);
            end
        endfunction

        function int unsigned pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  op        = 1'b0;
    logic [TIDX_W-1:0]     tidx      = '0;
    logic [COLOR_W-1:0]    tcolor    = '0;
    logic [DIM_W-1:0]      col       = '0;
    logic [DIM_W-1:0]      row       = '0;
    logic                  out_stall = 1'b0;

    wire                   in_stall;
    wire                   out_valid;
    wire [ADDR_W-1:0]      dest_address;
    wire [COLOR_W-1:0]     pixel_color;
    wire                   write_enable;
    wire [STATUS_W-1:0]    status;

    scaled_colorkey_sprite_blit_core u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_operation    (op),
        .i_texel_index  (tidx),
        .i_texel_color  (tcolor),
        .i_out_col      (col),
        .i_out_row      (row),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_dest_address (dest_address),
        .o_pixel_color  (pixel_color),
        .o_write_enable (write_enable),
        .o_status       (status)
    );

    pixel_scoreboard sb = new();

    t_blit_item  feed_q [$];        // items waiting to be offered
    int unsigned pushed   = 0;
    int unsigned accepted = 0;
    bit          loaded [TEXELS];   // store entries written so far, tracked at generation
    bit          hold_req = 1'b0;   // ask the receiver for one long hold-off

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sender: offer queued items in bursts of random length, with random
    // gaps between bursts. Hold the payload while the block stalls.
    // ------------------------------------------------------------------
    initial begin : feed_proc
        t_blit_item  cur;
        int unsigned burst_left, gap_left;
        bit          v;
        logic [31:0] junk;
        cur        = '0;
        burst_left = 1;
        gap_left   = 0;
        forever begin
            @(posedge clk);
            if (!(in_valid && in_stall)) begin
                if (in_valid) begin
                    sb.take_item(cur);
                    accepted++;
                end
                v = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (feed_q.size() > 0) begin
                    cur = feed_q.pop_front();
                    v   = 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        // Mix short choppy bursts with long unbroken stretches
                        if ($urandom_range(9, 0) < 3) begin
                            burst_left = $urandom_range(200, 50);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(12, 1);
                            gap_left   = ($urandom_range(9, 0) == 0) ? $urandom_range(30, 10)
                                                                     : $urandom_range(6, 0);
                        end
                    end
                end
                in_valid <= v;
                if (v) begin
                    op     <= cur.op;
                    tidx   <= cur.tidx;
                    tcolor <= cur.tcolor;
                    col    <= cur.col;
                    row    <= cur.row;
                end else begin
                    // Idle payload is noise; the block must ignore it
                    junk   = $urandom;
                    op     <= junk[0];
                    tidx   <= junk[TIDX_W:1];
                    tcolor <= $urandom;
                    col    <= junk[DIM_W+12:13];
                    row    <= junk[DIM_W+21:22];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: check each accepted result, then pick the next stall value
    // from a pattern that switches mode every so often.
    // ------------------------------------------------------------------
    initial begin : drain_proc
        t_drain_mode   mode;
        int unsigned   mode_left, hold_left;
        bit            s;
        t_pixel_result got;
        mode      = DRAIN_FREE;
        mode_left = 50;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                got = {dest_address, pixel_color, write_enable, status};
                sb.check_pixel(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                s = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_drain_mode'($urandom_range(4, 0));
                    mode_left = $urandom_range(200, 20);
                end
                mode_left--;
                case (mode)
                    DRAIN_FREE:     s = 1'b0;
                    DRAIN_LIGHT:    s = ($urandom_range(9, 0) < 3);
                    DRAIN_HEAVY:    s = ($urandom_range(9, 0) < 7);
                    DRAIN_PERIODIC: s = (mode_left % 3 == 0);
                    default: begin
                        // Short hold-off, then fall back to free flow
                        hold_left = $urandom_range(40, 15);
                        mode      = DRAIN_FREE;
                        s         = 1'b1;
                    end
                endcase
            end
            out_stall <= s;
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Configuration and stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(index, data);
    endtask

    // Fill the bits above a register's width with noise half of the time
    function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned v, int unsigned w);
        logic [CFG_DATA_W-1:0] j;
        j = $urandom;
        if ($urandom_range(1, 0) == 0) j = '0;
        return (j << w) | v;
    endfunction

    task automatic apply_setting(int unsigned sw, int unsigned sh, int unsigned ow,
                                 int unsigned oh, int unsigned org,
                                 logic [COLOR_W-1:0] key, bit en);
        write_reg(CFG_SPRITE_WIDTH,  with_junk(sw, SIDE_W));
        write_reg(CFG_SPRITE_HEIGHT, with_junk(sh, SIDE_W));
        write_reg(CFG_OUT_WIDTH,     with_junk(ow, DIM_W));
        write_reg(CFG_OUT_HEIGHT,    with_junk(oh, DIM_W));
        write_reg(CFG_ORIGIN_ROW,    with_junk(org, DIM_W));
        write_reg(CFG_KEY_COLOR,     key);
        write_reg(CFG_DRAW_ENABLE,   with_junk(en, 1));
    endtask

    // Wait until every item is in and every result is out, then let the pipe settle.
    task automatic drain_all();
        while (accepted != pushed) @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_SLACK) @(posedge clk);
    endtask

    function automatic logic [COLOR_W-1:0] pick_color();
        int unsigned r;
        r = $urandom_range(9, 0);
        if (r < 3) return sb.key;
        if (r == 3) return '0;
        if (r == 4) return '1;
        return $urandom;
    endfunction

    function automatic logic [DIM_W-1:0] rand_dim();
        logic [31:0] v;
        v = $urandom;
        return v[DIM_W-1:0];
    endfunction

    task automatic push_load(logic [TIDX_W-1:0] index, logic [COLOR_W-1:0] color);
        t_blit_item it;
        it        = '0;
        it.op     = OP_LOAD;
        it.tidx   = index;
        it.tcolor = color;
        loaded[index] = 1'b1;
        feed_q.push_back(it);
        pushed++;
    endtask

    // Precede a draw with a load when it would sample a never-written entry.
    task automatic push_draw(logic [DIM_W-1:0] c, logic [DIM_W-1:0] r);
        t_blit_item  it;
        int unsigned idx;
        if (sb.sample_index(c, r, idx) && !loaded[idx])
            push_load(TIDX_W'(idx), pick_color());
        it        = '0;
        it.op     = OP_DRAW;
        it.tcolor = $urandom;   // unused by a draw
        it.tidx   = TIDX_W'($urandom);
        it.col    = c;
        it.row    = r;
        feed_q.push_back(it);
        pushed++;
    endtask

    task automatic refused_case(int unsigned sw, int unsigned sh, int unsigned ow,
                                int unsigned oh, int unsigned org, bit en);
        apply_setting(sw, sh, ow, oh, org, $urandom, en);
        push_draw(1, 1);
        drain_all();
    endtask

    task automatic directed_part();
        // Reset values: drawing disabled, every draw refused
        push_load(0, '0);
        push_load(TIDX_W'(TEXELS - 1), '1);
        push_draw(0, 0);
        push_draw('1, '1);
        drain_all();

        // Largest sprite on the largest rectangle; the key matches texel 0
        apply_setting(SIDE_MAX, SIDE_MAX, SCR_W - 1, SCR_H, 0, '0, 1'b1);
        write_reg(CFG_UNUSED, $urandom);
        push_load(12'hAAA, 32'hAAAA_AAAA);
        push_load(12'h555, 32'h5555_5555);
        push_draw(0, 0);
        push_draw(DIM_W'(SCR_W - 2), DIM_W'(SCR_H - 1));
        push_draw(DIM_W'(SCR_W - 1), 0);
        push_draw(0, DIM_W'(SCR_H));
        drain_all();

        // Smallest sizes at the bottom row of the screen
        apply_setting(1, 1, 1, 1, SCR_H - 1, '1, 1'b1);
        push_draw(0, 0);
        push_draw(1, 0);
        push_draw(0, 1);
        drain_all();

        // Rectangle running past the bottom, sizes out of range, then an origin row off the screen
        refused_case(1, 1, 1, 2, SCR_H - 1, 1'b1);
        refused_case(0, 4, 8, 8, 0, 1'b1);
        refused_case(127, 4, 8, 8, 0, 1'b1);
        refused_case(4, 65, 8, 8, 0, 1'b1);
        refused_case(4, 4, 0, 8, 0, 1'b1);
        refused_case(4, 4, 8, 0, 0, 1'b1);
        refused_case(4, 4, 8, 1023, 0, 1'b1);
        refused_case(4, 4, 8, 8, 1023, 1'b1);
    endtask

    function automatic int unsigned pick_side();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 60) return $urandom_range(8, 1);
        if (r < 80) return $urandom_range(SIDE_MAX, 9);
        if (r < 90) return SIDE_MAX;
        return 1;
    endfunction

    function automatic int unsigned pick_span(int unsigned top);
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 40) return $urandom_range(32, 1);
        if (r < 70) return $urandom_range(top, 1);
        if (r < 85) return top;
        return 1;
    endfunction

    // Mostly legal settings; now and then one check is made to fail.
    task automatic random_setting();
        int unsigned sw, sh, ow, oh, org;
        bit          en;
        sw  = pick_side();
        sh  = pick_side();
        ow  = pick_span(SCR_W - 1);
        oh  = pick_span(SCR_H);
        org = ($urandom_range(4, 0) == 0) ? SCR_H - oh : $urandom_range(SCR_H - oh, 0);
        en  = 1'b1;
        case ($urandom_range(19, 0))
            0: en = 1'b0;
            1: sw = $urandom_range(1, 0) ? 0 : $urandom_range(127, SIDE_MAX + 1);
            2: sh = $urandom_range(1, 0) ? 0 : $urandom_range(127, SIDE_MAX + 1);
            3: ow = 0;
            4: oh = $urandom_range(1, 0) ? 0 : $urandom_range(1023, SCR_H + 1);
            5: org = $urandom_range(1023, SCR_H + 1 - oh);
            default: ;
        endcase
        apply_setting(sw, sh, ow, oh, org, $urandom, en);
    endtask

    task automatic random_item();
        int unsigned r;
        logic [DIM_W-1:0] c, w;
        r = $urandom_range(99, 0);
        if (r < 20) begin
            push_load(TIDX_W'($urandom), pick_color());
        end else if (r < 30) begin
            push_draw(rand_dim(), rand_dim());
        end else begin
            c = (sb.rect_w > 0 && sb.rect_w < SCR_W) ? DIM_W'($urandom_range(sb.rect_w - 1, 0))
                                                    : rand_dim();
            w = (sb.rect_h > 0 && sb.rect_h <= SCR_H) ? DIM_W'($urandom_range(sb.rect_h - 1, 0))
                                                     : rand_dim();
            // Hit the last column and row of the rectangle now and then
            if ($urandom_range(15, 0) == 0 && sb.rect_w > 0) c = DIM_W'(sb.rect_w - 1);
            if ($urandom_range(15, 0) == 0 && sb.rect_h > 0) w = DIM_W'(sb.rect_h - 1);
            push_draw(c, w);
        end
    endtask

    // Count every queued item, the loads placed ahead of draws too.
    task automatic random_part();
        int unsigned base, n;
        base = pushed;
        // First phase: long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        while (pushed - base < RANDOM_ITEMS) begin
            random_setting();
            n = $urandom_range(120, 40);
            if ($urandom_range(3, 0) == 0) hold_req = 1'b1;
            repeat (n) random_item();
            drain_all();
        end
    endtask

    initial begin : main_proc
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();
        random_part();
        drain_all();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
